// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the key press rate monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/kprm_pkg.sv =====
// Package of the key press rate monitor: beat types, field codes and reset values.
package kprm_pkg;

  typedef struct packed {
    logic        mode;
    logic [1:0]  source_id;
    logic [31:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic        error_kind;
    logic [1:0]  report_group;
    logic [31:0] interval_first;
    logic [31:0] interval_second;
    logic [15:0] count_first;
    logic [15:0] count_second;
    logic        last;
  } out_beat_t;

  // Input modes
  localparam logic MODE_PRESS  = 1'b0;
  localparam logic MODE_WINDOW = 1'b1;

  // Event sources
  localparam logic [1:0] SRC_VUP  = 2'd0;
  localparam logic [1:0] SRC_VDN  = 2'd1;
  localparam logic [1:0] SRC_PWR  = 2'd2;
  localparam logic [1:0] SRC_HALL = 2'd3;

  // Report groups
  localparam logic [1:0] GRP_VOL  = 2'd0;
  localparam logic [1:0] GRP_PWR  = 2'd1;
  localparam logic [1:0] GRP_HALL = 2'd2;

  // Error kinds
  localparam logic KIND_INTERVAL = 1'b0;
  localparam logic KIND_COUNT    = 1'b1;

  // Configuration register indexes
  localparam logic CFG_MIN_INTERVAL = 1'b0;
  localparam logic CFG_MAX_COUNT    = 1'b1;

  localparam int          CFG_BITS          = 16;
  localparam logic [15:0] MIN_INTERVAL_RST  = 16'd165;
  localparam logic [15:0] MAX_COUNT_RST     = 16'd120;

endpackage

// ===== hdl/key_press_rate_monitor.sv =====
// Top level of the key press rate monitor: press/window processing and report queue.
//
// Usage:
//   in_*  : valid/ready channel of event beats. mode 0 is a press of source_id at
//           timestamp now_ms; mode 1 closes the statistics window.
//   out_* : valid/ready channel of error reports. A press beat yields zero or one
//           report (interval too short); a window beat yields zero to three count
//           reports in the order power, volume, hall. The final report of a beat
//           carries last = 1.
//   cfg_* : plain write port; index 0 is min_interval_ms, index 1 is max_count.
//           Write only while no beat is in flight.
// Throughput: one beat per cycle while each beat yields at most one report and
//   out_* is not stalled; a beat with more reports holds the input until the
//   three-slot report queue, which drains one report a cycle into the output
//   register whenever that is free or being read, is down to its last report.
// Reset: counts, press times and intervals clear to zero, the configuration
//   registers return to 165 ms and 120 presses, and all queues empty.
// Stall: when out_ready is low the output register holds; the report queue and
//   the input register keep filling and in_ready drops once both are occupied.
`include "assert_macros.svh"

module key_press_rate_monitor #(
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kprm_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kprm_pkg::out_beat_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata
);

  localparam int CMP_W = (COUNT_BITS > kprm_pkg::CFG_BITS) ? COUNT_BITS : kprm_pkg::CFG_BITS;

  // Configuration registers
  logic [15:0] min_interval_r;
  logic [15:0] max_count_r;

  // Per-source state
  logic [COUNT_BITS-1:0] cnt_r  [4];
  logic [TIME_BITS-1:0]  time_r [4];
  logic [TIME_BITS-1:0]  ival_r [4];

  // Input register
  logic                in_valid_r;
  kprm_pkg::in_beat_t  in_data_r;

  // Report queue and output register
  kprm_pkg::out_beat_t slot_r [3];
  logic [1:0]          burst_cnt_r;
  logic                out_valid_r;
  kprm_pkg::out_beat_t out_data_r;

  // Processing signals
  logic                  take;
  logic                  drain;
  logic [1:0]            src;
  logic [TIME_BITS-1:0]  now_t;
  logic [TIME_BITS-1:0]  diff;
  logic [TIME_BITS-1:0]  slack;
  logic                  press_err;
  logic                  is_press;
  logic [COUNT_BITS-1:0] cnt_post  [4];
  logic [TIME_BITS-1:0]  ival_post [4];
  logic                  f_pwr, f_vol, f_hall;
  kprm_pkg::out_beat_t   rep_pwr, rep_vol, rep_hall;
  kprm_pkg::out_beat_t   new_slot [3];
  logic [1:0]            new_cnt;

  // Handshake control
  assign drain    = (burst_cnt_r != 2'd0) && (!out_valid_r || out_ready);
  assign take     = in_valid_r && ((burst_cnt_r == 2'd0) || ((burst_cnt_r == 2'd1) && drain));
  assign in_ready = !in_valid_r || take;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Press arithmetic: modular interval and signed slack against the minimum
  assign is_press = (in_data_r.mode == kprm_pkg::MODE_PRESS);
  assign src      = in_data_r.source_id;
  assign now_t    = TIME_BITS'(in_data_r.now_ms);
  assign diff     = now_t - time_r[src];
  assign slack    = diff - TIME_BITS'(min_interval_r);
  assign press_err = slack[TIME_BITS-1];

  // State as it stands after a press update (unchanged on a window beat)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cnt_post[i]  = cnt_r[i];
      ival_post[i] = ival_r[i];
    end
    if (is_press) begin
      if (cnt_r[src] != {COUNT_BITS{1'b1}}) begin
        cnt_post[src] = cnt_r[src] + COUNT_BITS'(1);
      end
      ival_post[src] = diff;
    end
  end

  // Which groups report
  always_comb begin
    if (is_press) begin
      f_pwr  = press_err && (src == kprm_pkg::SRC_PWR);
      f_vol  = press_err && ((src == kprm_pkg::SRC_VUP) || (src == kprm_pkg::SRC_VDN));
      f_hall = press_err && (src == kprm_pkg::SRC_HALL);
    end else begin
      f_pwr  = CMP_W'(cnt_r[kprm_pkg::SRC_PWR]) > CMP_W'(max_count_r);
      f_vol  = (CMP_W'(cnt_r[kprm_pkg::SRC_VUP]) > CMP_W'(max_count_r)) ||
               (CMP_W'(cnt_r[kprm_pkg::SRC_VDN]) > CMP_W'(max_count_r));
      f_hall = CMP_W'(cnt_r[kprm_pkg::SRC_HALL]) > CMP_W'(max_count_r);
    end
  end

  // Build the three candidate reports; last marks the final one that is present
  always_comb begin
    rep_pwr.error_kind      = is_press ? kprm_pkg::KIND_INTERVAL : kprm_pkg::KIND_COUNT;
    rep_pwr.report_group    = kprm_pkg::GRP_PWR;
    rep_pwr.interval_first  = 32'(ival_post[kprm_pkg::SRC_PWR]);
    rep_pwr.interval_second = '0;
    rep_pwr.count_first     = 16'(cnt_post[kprm_pkg::SRC_PWR]);
    rep_pwr.count_second    = '0;
    rep_pwr.last            = !f_vol && !f_hall;

    rep_vol.error_kind      = rep_pwr.error_kind;
    rep_vol.report_group    = kprm_pkg::GRP_VOL;
    rep_vol.interval_first  = 32'(ival_post[kprm_pkg::SRC_VUP]);
    rep_vol.interval_second = 32'(ival_post[kprm_pkg::SRC_VDN]);
    rep_vol.count_first     = 16'(cnt_post[kprm_pkg::SRC_VUP]);
    rep_vol.count_second    = 16'(cnt_post[kprm_pkg::SRC_VDN]);
    rep_vol.last            = !f_hall;

    rep_hall.error_kind      = rep_pwr.error_kind;
    rep_hall.report_group    = kprm_pkg::GRP_HALL;
    rep_hall.interval_first  = 32'(ival_post[kprm_pkg::SRC_HALL]);
    rep_hall.interval_second = '0;
    rep_hall.count_first     = 16'(cnt_post[kprm_pkg::SRC_HALL]);
    rep_hall.count_second    = '0;
    rep_hall.last            = 1'b1;
  end

  // Compact present reports into queue slots, power first
  always_comb begin
    new_slot[0] = f_pwr ? rep_pwr : (f_vol ? rep_vol : rep_hall);
    new_slot[1] = (f_pwr && f_vol) ? rep_vol : rep_hall;
    new_slot[2] = rep_hall;
    new_cnt     = 2'(f_pwr) + 2'(f_vol) + 2'(f_hall);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= kprm_pkg::MIN_INTERVAL_RST;
      max_count_r    <= kprm_pkg::MAX_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kprm_pkg::CFG_MIN_INTERVAL: min_interval_r <= cfg_wdata;
        kprm_pkg::CFG_MAX_COUNT:    max_count_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-source state: commit the press update, or clear counts at window end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        cnt_r[i]  <= '0;
        time_r[i] <= '0;
        ival_r[i] <= '0;
      end
    end else if (take) begin
      if (is_press) begin
        cnt_r[src]  <= cnt_post[src];
        ival_r[src] <= ival_post[src];
        time_r[src] <= now_t;
      end else begin
        for (int i = 0; i < 4; i++) begin
          cnt_r[i] <= '0;
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (take) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Report queue: load a whole burst on take, else advance one slot per drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_cnt_r <= 2'd0;
    end else if (take) begin
      burst_cnt_r <= new_cnt;
    end else if (drain) begin
      burst_cnt_r <= burst_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot_r[0] <= new_slot[0];
      slot_r[1] <= new_slot[1];
      slot_r[2] <= new_slot[2];
    end else if (drain) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (drain) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_data_r <= slot_r[0];
    end
  end

  // A report that is not the last of its beat always has a follower queued
  `ASSERT_IMPL(a_follower_queued, out_valid_r && !out_data_r.last, burst_cnt_r != 2'd0,
               "non-final report without queued follower")

  // A press never produces more than one report
  `ASSERT_IMPL(a_press_single, take && is_press, new_cnt <= 2'd1,
               "press produced more than one report")

  // Window end clears the power count
  `ASSERT_NEXT(a_window_clear, take && !is_press, cnt_r[kprm_pkg::SRC_PWR] == '0,
               "count not cleared after window end")

  // The queue is only reloaded once it is empty or emptying
  `ASSERT_NEXT(a_queue_bound, take, burst_cnt_r <= 2'd3 && $past(burst_cnt_r) <= 2'd1,
               "report queue reloaded while still holding reports")

endmodule

// ===== bench/kprm_checker.sv =====
// Checker of the key press rate monitor: tracks beats, predicts error reports and compares them.
module kprm_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  kprm_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  kprm_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  output int                  mismatch_count,
  output int                  reports_due
);

  logic [15:0]         press_cnt [4];
  logic [31:0]         press_time [4];
  logic [31:0]         press_gap [4];
  logic [15:0]         min_gap;
  logic [15:0]         cnt_limit;
  kprm_pkg::out_beat_t report_fifo [$];

  // Snapshot one group's intervals and counts as they stand now.
  function automatic kprm_pkg::out_beat_t build_report(logic kind, logic [1:0] grp);
    kprm_pkg::out_beat_t r;
    logic [1:0]          a;
    a = (grp == kprm_pkg::GRP_VOL) ? kprm_pkg::SRC_VUP :
        ((grp == kprm_pkg::GRP_PWR) ? kprm_pkg::SRC_PWR : kprm_pkg::SRC_HALL);
    r.error_kind      = kind;
    r.report_group    = grp;
    r.interval_first  = press_gap[a];
    r.interval_second = (grp == kprm_pkg::GRP_VOL) ? press_gap[kprm_pkg::SRC_VDN] : 32'd0;
    r.count_first     = press_cnt[a];
    r.count_second    = (grp == kprm_pkg::GRP_VOL) ? press_cnt[kprm_pkg::SRC_VDN] : 16'd0;
    r.last            = 1'b0;
    return r;
  endfunction

  task automatic predict_beat(input kprm_pkg::in_beat_t b);
    kprm_pkg::out_beat_t batch [$];
    kprm_pkg::out_beat_t tail;
    logic [31:0]         slack;
    logic [1:0]          src;
    logic [1:0]          grp;
    src = b.source_id;
    if (b.mode == kprm_pkg::MODE_PRESS) begin
      if (press_cnt[src] != 16'hFFFF) press_cnt[src] = press_cnt[src] + 16'd1;
      slack = b.now_ms - press_time[src] - {16'd0, min_gap};
      press_gap[src]  = b.now_ms - press_time[src];
      press_time[src] = b.now_ms;
      if (slack[31]) begin
        grp = (src == kprm_pkg::SRC_VUP || src == kprm_pkg::SRC_VDN) ? kprm_pkg::GRP_VOL :
              ((src == kprm_pkg::SRC_PWR) ? kprm_pkg::GRP_PWR : kprm_pkg::GRP_HALL);
        batch.push_back(build_report(kprm_pkg::KIND_INTERVAL, grp));
      end
    end else begin
      if (press_cnt[kprm_pkg::SRC_PWR] > cnt_limit)
        batch.push_back(build_report(kprm_pkg::KIND_COUNT, kprm_pkg::GRP_PWR));
      if (press_cnt[kprm_pkg::SRC_VUP] > cnt_limit || press_cnt[kprm_pkg::SRC_VDN] > cnt_limit)
        batch.push_back(build_report(kprm_pkg::KIND_COUNT, kprm_pkg::GRP_VOL));
      if (press_cnt[kprm_pkg::SRC_HALL] > cnt_limit)
        batch.push_back(build_report(kprm_pkg::KIND_COUNT, kprm_pkg::GRP_HALL));
      for (int i = 0; i < 4; i++) press_cnt[i] = 16'd0;
    end
    if (batch.size() > 0) begin
      tail = batch.pop_back();
      tail.last = 1'b1;
      batch.push_back(tail);
    end
    foreach (batch[i]) report_fifo.push_back(batch[i]);
  endtask

  task automatic check_report(input kprm_pkg::out_beat_t got);
    kprm_pkg::out_beat_t want;
    if (report_fifo.size() == 0) begin
      if (mismatch_count < 10) $display("unexpected report: %p", got);
      mismatch_count++;
    end else begin
      want = report_fifo.pop_front();
      if (got.error_kind !== want.error_kind || got.report_group !== want.report_group ||
          got.interval_first !== want.interval_first ||
          got.interval_second !== want.interval_second ||
          got.count_first !== want.count_first || got.count_second !== want.count_second ||
          got.last !== want.last) begin
        if (mismatch_count < 10) begin
          $display("report mismatch: expected %p", want);
          $display("                 actual   %p", got);
        end
        mismatch_count++;
      end
    end
  endtask

  // Results leave before new beats land; a result never belongs to a same-edge beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        press_cnt[i]  = 16'd0;
        press_time[i] = 32'd0;
        press_gap[i]  = 32'd0;
      end
      min_gap   = kprm_pkg::MIN_INTERVAL_RST;
      cnt_limit = kprm_pkg::MAX_COUNT_RST;
      report_fifo.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) check_report(out_data);
      if (cfg_we) begin
        if (cfg_index == kprm_pkg::CFG_MIN_INTERVAL) min_gap = cfg_wdata;
        else cnt_limit = cfg_wdata;
      end
      if (in_valid && in_ready) predict_beat(in_data);
    end
    reports_due = report_fifo.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the key press rate monitor bench: clock, reset, stimulus, back-pressure and verdict.
module testbench;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  kprm_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  kprm_pkg::out_beat_t out_data;
  logic                cfg_we;
  logic                cfg_index;
  logic [15:0]         cfg_wdata;

  int          mismatch_count;
  int          reports_due;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [31:0] stamp_ms;

  key_press_rate_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  kprm_checker report_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .reports_due    (reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: drop ready at random, per cycle, at the rate of the current phase.
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic kprm_pkg::in_beat_t beat(logic mode, logic [1:0] src, logic [31:0] now);
    kprm_pkg::in_beat_t b;
    b.mode      = mode;
    b.source_id = src;
    b.now_ms    = now;
    return b;
  endfunction

  // Random beat: mostly presses on a running clock so intervals sit near the limit,
  // with some backward jumps, fully random stamps and window ends carrying noise.
  function automatic kprm_pkg::in_beat_t rand_beat();
    int          roll;
    logic [31:0] now;
    roll = $urandom_range(0, 99);
    if (roll < 14) return beat(kprm_pkg::MODE_WINDOW, 2'($urandom_range(0, 3)), $urandom);
    roll = $urandom_range(0, 19);
    if (roll == 0) now = $urandom;
    else if (roll == 1) now = stamp_ms - 32'($urandom_range(0, 50));
    else now = stamp_ms + 32'($urandom_range(0, 400));
    stamp_ms = now;
    return beat(kprm_pkg::MODE_PRESS, 2'($urandom_range(0, 3)), now);
  endfunction

  // Offer one beat at a falling edge and hold it until the rising edge that takes it.
  // Return at the next falling edge without touching valid, so the caller's next
  // drive is the only assignment in that step.
  task automatic send_beat(input kprm_pkg::in_beat_t b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait out every pending report, then wait on for
  // beats that produce nothing but may still be in the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Pulse the write enable for one cycle, then lower it and wait before returning.
  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int wait_cycles;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = kprm_pkg::CFG_MIN_INTERVAL;
    cfg_wdata     = '0;
    send_idle_pct = 23;
    recv_idle_pct = 87;
    stamp_ms      = 32'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset settings: 165 ms spacing, limit of 120 presses.
    send_beat(beat(kprm_pkg::MODE_PRESS, kprm_pkg::SRC_VUP, 32'd0));    // first press, from zero
    send_beat(beat(kprm_pkg::MODE_PRESS, kprm_pkg::SRC_VDN, 32'd200));
    send_beat(beat(kprm_pkg::MODE_PRESS, kprm_pkg::SRC_PWR, 32'd164));  // one short of the limit
    send_beat(beat(kprm_pkg::MODE_PRESS, kprm_pkg::SRC_PWR, 32'd329));  // exactly at the limit
    send_beat(beat(kprm_pkg::MODE_PRESS, kprm_pkg::SRC_HALL, 32'hFFFF_FFFF)); // slack wraps
    send_beat(beat(kprm_pkg::MODE_PRESS, kprm_pkg::SRC_HALL, 32'h0000_0010)); // stamp wraps
    send_beat(beat(kprm_pkg::MODE_WINDOW, kprm_pkg::SRC_HALL, 32'hFFFF_FFFF)); // quiet window

    // Tightest limits: gaps under 65535 ms trip the spacing check, any count trips the limit.
    settle();
    write_reg(kprm_pkg::CFG_MAX_COUNT, 16'd0);
    write_reg(kprm_pkg::CFG_MIN_INTERVAL, 16'hFFFF);
    send_beat(beat(kprm_pkg::MODE_PRESS, kprm_pkg::SRC_VUP, 32'd1000));
    send_beat(beat(kprm_pkg::MODE_PRESS, kprm_pkg::SRC_PWR, 32'd1000));
    send_beat(beat(kprm_pkg::MODE_PRESS, kprm_pkg::SRC_HALL, 32'd1000));
    send_beat(beat(kprm_pkg::MODE_PRESS, kprm_pkg::SRC_VDN, 32'd70000)); // gap beyond 16 bits
    send_beat(beat(kprm_pkg::MODE_WINDOW, kprm_pkg::SRC_VUP, 32'd0));    // all groups, power first
    send_beat(beat(kprm_pkg::MODE_WINDOW, kprm_pkg::SRC_PWR, 32'h5A5A_A5A5)); // counts cleared

    // Loosest limits.
    settle();
    write_reg(kprm_pkg::CFG_MIN_INTERVAL, 16'd0);
    write_reg(kprm_pkg::CFG_MAX_COUNT, 16'hFFFF);
    send_beat(beat(kprm_pkg::MODE_PRESS, kprm_pkg::SRC_VUP, 32'd0));   // backward jump
    send_beat(beat(kprm_pkg::MODE_PRESS, kprm_pkg::SRC_VUP, 32'd0));   // zero gap, zero slack
    send_beat(beat(kprm_pkg::MODE_WINDOW, kprm_pkg::SRC_VDN, 32'd0));

    // Random phases: sender-light/receiver-heavy idling, then the reverse, then none.
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(kprm_pkg::CFG_MIN_INTERVAL, 16'($urandom_range(100, 400)));
          write_reg(kprm_pkg::CFG_MAX_COUNT, 16'($urandom_range(0, 3)));
          send_idle_pct = 23;
          recv_idle_pct = 87;
        end
        1: begin
          write_reg(kprm_pkg::CFG_MIN_INTERVAL, 16'($urandom));
          write_reg(kprm_pkg::CFG_MAX_COUNT, 16'd1);
          send_idle_pct = 87;
          recv_idle_pct = 23;
        end
        default: begin
          write_reg(kprm_pkg::CFG_MIN_INTERVAL, kprm_pkg::MIN_INTERVAL_RST);
          write_reg(kprm_pkg::CFG_MAX_COUNT, 16'd2);
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (115) send_beat(rand_beat());
    end

    // Drain: bounded wait for the last reports, then quiet before the verdict.
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (reports_due != 0 && wait_cycles < 50000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && reports_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
